// File: sv/bchd_pkg.sv
// ----------------------------------------------------------------------------
// bchd_pkg - shared types and constants of the button click detector
// Event kinds, the per-button entry passed from front to back, register
// indexes and reset values, and port layout constants.
// ----------------------------------------------------------------------------
package bchd_pkg;

	// default number of button lanes
	localparam int NUM_BUTTONS_DEF = 5;
	// buttons that the input word carries
	localparam int IN_BUTTONS      = 5;

	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 8;
	localparam int VAL_W     = 16;
	localparam int AMOUNT_W  = 8;
	localparam int BUTTON_W  = 3;
	localparam int KIND_W    = 2;
	localparam int CLICK_W   = 8;

	// stream word layouts
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 16;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// event kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_PRESS   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_COUNT   = 2'd2,
		KIND_HOLD    = 2'd3
	} kind_t;

	// one button's event: click count or held milliseconds in val
	typedef struct packed {
		kind_t            kind;
		logic [VAL_W-1:0] val;
	} entry_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IGNORE      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_MIN    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_REPEAT = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_MAX    = 8'd4;

	// register reset values
	localparam logic [CFG_W-1:0] IGNORE_RST      = 16'd50;
	localparam logic [CFG_W-1:0] DOUBLE_RST      = 16'd250;
	localparam logic [CFG_W-1:0] HOLD_MIN_RST    = 16'd1000;
	localparam logic [CFG_W-1:0] HOLD_REPEAT_RST = 16'd1000;
	localparam logic [CFG_W-1:0] HOLD_MAX_RST    = 16'd20500;

	localparam logic [CLICK_W-1:0] CLICK_MAX = 8'hFF;

endpackage

// File: sv/button_click_holddown_detector.sv
// ----------------------------------------------------------------------------
// button_click_holddown_detector - button press, click and hold events
// Classifies timestamped button samples into press, release, click-count and
// hold events per button.
// ----------------------------------------------------------------------------
// Each accepted sample (a word of button bits and a millisecond timestamp) is
// evaluated for all buttons in parallel and leaves zero to one event per
// button; events come out on the master stream one word per cycle while
// tready is high, lowest button first, with tlast on the last event of the
// sample. A sample without events never reaches the queue. A two-entry
// record queue sits between the classifier and the output, so samples keep
// being accepted while events wait on tready, as long as the queue has room.
// The first event of a sample is registered in the queue and then in the
// output register.
// Configuration writes are always ready and belong in idle periods.
module button_click_holddown_detector #(
	parameter int NUM_BUTTONS = bchd_pkg::NUM_BUTTONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// samples: [4:0] buttons, [36:5] now_ms
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bchd_pkg::S_TDATA_W-1:0] s_tdata,
	// events: [2:0] button, [10:3] amount
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bchd_pkg::M_TDATA_W-1:0] m_tdata,
	// events: [1:0] kind
	output logic [bchd_pkg::KIND_W-1:0]    m_tuser,
	output logic                           m_tlast,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bchd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bchd_pkg::CFG_W-1:0]     cfg_data
);
	import bchd_pkg::*;

	localparam int REC_W = NUM_BUTTONS + NUM_BUTTONS * $bits(entry_t);

	logic                           push_valid;
	logic                           push_ready;
	logic [NUM_BUTTONS-1:0]         push_mask;
	entry_t [NUM_BUTTONS-1:0]       push_ent;
	logic                           head_valid;
	logic                           head_pop;
	logic [NUM_BUTTONS-1:0]         head_mask;
	entry_t [NUM_BUTTONS-1:0]       head_ent;
	logic [REC_W-1:0]               push_rec;
	logic [REC_W-1:0]               head_rec;

	// record packing around the queue
	assign push_rec              = {push_mask, push_ent};
	assign {head_mask, head_ent} = head_rec;

	bchd_front #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_mask  (push_mask),
		.push_ent   (push_ent)
	);

	bchd_queue #(
		.WIDTH (REC_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_rec),
		.pop_valid  (head_valid),
		.pop_ready  (head_pop),
		.pop_data   (head_rec)
	);

	bchd_back #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.head_mask  (head_mask),
		.head_ent   (head_ent),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// File: sv/bchd_front.sv
// ----------------------------------------------------------------------------
// bchd_front - sample intake and per-button classification
// Holds the configuration registers and every button's state, evaluates all
// button lanes in parallel on an accepted sample and pushes one record with
// the event mask and per-button entries into the queue if any lane has an event.
// ----------------------------------------------------------------------------
module bchd_front #(
	parameter int NUM_BUTTONS = bchd_pkg::NUM_BUTTONS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [bchd_pkg::S_TDATA_W-1:0]       s_tdata,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bchd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bchd_pkg::CFG_W-1:0]           cfg_data,
	// record towards the queue
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output logic [NUM_BUTTONS-1:0]               push_mask,
	output bchd_pkg::entry_t [NUM_BUTTONS-1:0]   push_ent
);
	import bchd_pkg::*;

	logic                  accept;
	logic [IN_BUTTONS-1:0] buttons;
	logic [TIME_W-1:0]     now_ms;

	logic [CFG_W-1:0] ignore_q;
	logic [CFG_W-1:0] double_q;
	logic [CFG_W-1:0] hold_min_q;
	logic [CFG_W-1:0] hold_repeat_q;
	logic [CFG_W-1:0] hold_max_q;

	// per-lane flags exported for checking
	logic [NUM_BUTTONS-1:0] hv_v;
	logic [NUM_BUTTONS-1:0] pv_v;
	logic [NUM_BUTTONS-1:0] rv_v;
	logic [NUM_BUTTONS-1:0] cc_nz_v;

	// input word unpack
	assign buttons = s_tdata[IN_BUTTONS-1:0];
	assign now_ms  = s_tdata[IN_BUTTONS +: TIME_W];

	assign s_tready   = push_ready;
	assign accept     = s_tvalid & s_tready;
	assign push_valid = accept & (|push_mask);
	assign cfg_ready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_q      <= IGNORE_RST;
			double_q      <= DOUBLE_RST;
			hold_min_q    <= HOLD_MIN_RST;
			hold_repeat_q <= HOLD_REPEAT_RST;
			hold_max_q    <= HOLD_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IGNORE:      ignore_q      <= cfg_data;
				REG_DOUBLE:      double_q      <= cfg_data;
				REG_HOLD_MIN:    hold_min_q    <= cfg_data;
				REG_HOLD_REPEAT: hold_repeat_q <= cfg_data;
				REG_HOLD_MAX:    hold_max_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		logic               pressed_q;
		logic               rv_q;
		logic               pv_q;
		logic               hv_q;
		logic [TIME_W-1:0]  rt_q;
		logic [TIME_W-1:0]  pt_q;
		logic [TIME_W-1:0]  ht_q;
		logic [CLICK_W-1:0] cc_q;

		logic              down;
		logic [TIME_W-1:0] d_rel;
		logic [TIME_W-1:0] held;
		logic [TIME_W-1:0] d_hold;
		logic              press_ev;
		logic              rel_ev;
		logic              still_down;
		logic              clr;
		logic              count_ev;
		logic              spaced;
		logic              hold_ev;
		entry_t            ent;

		// lanes past the input word never see a press
		if (b < IN_BUTTONS) begin : g_in
			assign down = buttons[b];
		end else begin : g_none
			assign down = 1'b0;
		end

		// wrapping time differences
		assign d_rel  = now_ms - rt_q;
		assign held   = now_ms - pt_q;
		assign d_hold = now_ms - ht_q;

		// classification
		assign press_ev   = down & ~pressed_q &
			~(rv_q & (d_rel < TIME_W'(ignore_q)));
		assign rel_ev     = ~down & pressed_q;
		assign still_down = down & (pressed_q | press_ev);
		assign clr        = ~rel_ev & rv_q & ~still_down & (d_rel > TIME_W'(double_q));
		assign count_ev   = clr & ~hv_q;
		assign spaced     = ~hv_q | (d_hold > TIME_W'(hold_repeat_q));
		assign hold_ev    = down & pressed_q & pv_q & (held > TIME_W'(hold_min_q)) &
			spaced & (held < TIME_W'(hold_max_q));

		// entry for the back end
		always_comb begin
			ent.kind = KIND_PRESS;
			ent.val  = '0;
			priority if (press_ev) begin
				ent.kind = KIND_PRESS;
			end else if (rel_ev) begin
				ent.kind = KIND_RELEASE;
			end else if (count_ev) begin
				ent.kind = KIND_COUNT;
				ent.val  = VAL_W'(cc_q);
			end else if (hold_ev) begin
				ent.kind = KIND_HOLD;
				ent.val  = held[VAL_W-1:0];
			end else begin
				// no event, entry is masked off
				ent.kind = KIND_PRESS;
			end
		end

		assign push_mask[b] = press_ev | rel_ev | count_ev | hold_ev;
		assign push_ent[b]  = ent;

		// button state update on an accepted sample
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pressed_q <= 1'b0;
				rv_q      <= 1'b0;
				pv_q      <= 1'b0;
				hv_q      <= 1'b0;
				rt_q      <= '0;
				pt_q      <= '0;
				ht_q      <= '0;
				cc_q      <= '0;
			end else if (accept) begin
				if (press_ev) begin
					pressed_q <= 1'b1;
					pt_q      <= now_ms;
					pv_q      <= 1'b1;
				end
				if (rel_ev) begin
					if (cc_q != CLICK_MAX) begin
						cc_q <= cc_q + CLICK_W'(1);
					end
					rt_q      <= now_ms;
					rv_q      <= 1'b1;
					pressed_q <= 1'b0;
				end
				if (clr) begin
					rv_q <= 1'b0;
					rt_q <= '0;
					hv_q <= 1'b0;
					ht_q <= '0;
					cc_q <= '0;
				end
				if (hold_ev) begin
					ht_q <= now_ms;
					hv_q <= 1'b1;
				end
			end
		end

		assign hv_v[b]    = hv_q;
		assign pv_v[b]    = pv_q;
		assign rv_v[b]    = rv_q;
		assign cc_nz_v[b] = |cc_q;
	end

	// a hold is only ever recorded after a press
	a_hold_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		(hv_v & ~pv_v) == '0)
		else $error("hold marked without a recorded press");

	// clicks are only counted while a release is pending
	a_count_needs_release: assert property (@(posedge clk) disable iff (!arst_n)
		(cc_nz_v & ~rv_v) == '0)
		else $error("click count without a pending release");

endmodule

// File: sv/bchd_queue.sv
// ----------------------------------------------------------------------------
// bchd_queue - short record queue between front and back
// Register-based FIFO; ready towards the front depends on fill only.
// ----------------------------------------------------------------------------
module bchd_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import bchd_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (AW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue fill count past depth");

endmodule

// File: sv/bchd_back.sv
// ----------------------------------------------------------------------------
// bchd_back - event emission
// Walks the head record's event mask from the lowest button up, one event per
// cycle while the output is not stalled, turns held milliseconds into whole
// seconds and drives the output register.
// ----------------------------------------------------------------------------
module bchd_back #(
	parameter int NUM_BUTTONS = bchd_pkg::NUM_BUTTONS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// head of the queue
	input  logic                                 head_valid,
	output logic                                 head_pop,
	input  logic [NUM_BUTTONS-1:0]               head_mask,
	input  bchd_pkg::entry_t [NUM_BUTTONS-1:0]   head_ent,
	// event stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bchd_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic [bchd_pkg::KIND_W-1:0]          m_tuser,
	output logic                                 m_tlast
);
	import bchd_pkg::*;

	localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	// ms to seconds: (ms >> 3) * 8389 >> 20, exact for ms below 65536
	localparam int PRE_SHIFT  = 3;
	localparam int H8_W       = VAL_W - PRE_SHIFT;
	localparam int MULT_W     = 14;
	localparam logic [MULT_W-1:0] SEC_MULT = 14'd8389;
	localparam int SEC_SHIFT  = 20;
	localparam int PROD_W     = H8_W + MULT_W;
	localparam int SECS_W     = PROD_W - SEC_SHIFT;

	logic [NUM_BUTTONS-1:0] done_q;
	logic [NUM_BUTTONS-1:0] pending;
	logic [NUM_BUTTONS-1:0] lowest;
	logic [NUM_BUTTONS-1:0] rest;
	logic [IDX_W-1:0]       sel;
	entry_t                 ent_sel;
	logic [PROD_W-1:0]      prod;
	logic [AMOUNT_W-1:0]    amount;
	logic                   emit;
	logic                   last;

	logic                m_valid_q;
	logic [BUTTON_W-1:0] button_q;
	logic [AMOUNT_W-1:0] amount_q;
	kind_t               kind_q;
	logic                last_q;

	// next event of the head record
	assign pending = head_mask & ~done_q;
	assign lowest  = pending & (~pending + NUM_BUTTONS'(1));
	assign rest    = pending & ~lowest;
	assign last    = (rest == '0);

	always_comb begin
		sel = '0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (pending[i]) begin
				sel = IDX_W'(i);
			end
		end
	end

	assign ent_sel = head_ent[sel];

	// whole seconds held
	assign prod   = PROD_W'(ent_sel.val[VAL_W-1:PRE_SHIFT]) * PROD_W'(SEC_MULT);
	assign amount = (ent_sel.kind == KIND_HOLD) ?
		AMOUNT_W'(prod[PROD_W-1:SEC_SHIFT]) : ent_sel.val[AMOUNT_W-1:0];

	assign emit     = head_valid & (~m_valid_q | m_tready);
	assign head_pop = emit & last;

	// progress through the head record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (emit) begin
			done_q <= last ? '0 : (done_q | lowest);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			button_q <= BUTTON_W'({1'b0, sel} + (IDX_W + 1)'(1));
			amount_q <= amount;
			kind_q   <= ent_sel.kind;
			last_q   <= last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(M_TDATA_W - AMOUNT_W - BUTTON_W)'(0), amount_q, button_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	a_head_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (pending != '0))
		else $error("queue head without pending event");

	a_done_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ((done_q & ~head_mask) == '0))
		else $error("emitted bits outside the head mask");

	a_seconds_range: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && ent_sel.kind == KIND_HOLD) |-> (prod[PROD_W-1:SEC_SHIFT] <= SECS_W'(65)))
		else $error("hold seconds out of range");

endmodule
